// ----- rtl/qrm_pkg.sv -----
// qrm_pkg: shared types and constants for the quaternion to rotation matrix block
// used by qrm_divider and quaternion_to_rotation_matrix; depends on nothing

package qrm_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int LEN_W      = 2 * DATA_WIDTH;
  localparam int MAG_W      = LEN_W + 1;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int N_ENT      = 9;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m_r0c0;
    logic signed [DATA_WIDTH-1:0] m_r0c1;
    logic signed [DATA_WIDTH-1:0] m_r0c2;
    logic signed [DATA_WIDTH-1:0] m_r1c0;
    logic signed [DATA_WIDTH-1:0] m_r1c1;
    logic signed [DATA_WIDTH-1:0] m_r1c2;
    logic signed [DATA_WIDTH-1:0] m_r2c0;
    logic signed [DATA_WIDTH-1:0] m_r2c1;
    logic signed [DATA_WIDTH-1:0] m_r2c2;
    logic                         zero_length;
  } result_t;

  // numerators and squared length handed to the divider
  typedef struct packed {
    logic                              vld;
    logic                              zero;
    logic [LEN_W-1:0]                  len;
    logic [N_ENT-1:0]                  neg;
    logic [N_ENT-1:0][MAG_W-1:0]       mag;
  } div_in_t;

endpackage

// ----- rtl/qrm_divider.sv -----
// qrm_divider: nine-lane pipelined restoring divider, one quotient bit per stage,
// with round to nearest and sign restore; depends on qrm_pkg

module qrm_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  qrm_pkg::div_in_t      din,
  output logic                  done,
  output qrm_pkg::result_t      result
);

  localparam int STEPS = qrm_pkg::Q_W;

  typedef struct packed {
    logic                         full;
    logic                         neg;
    logic [qrm_pkg::LEN_W-1:0]    r;
    logic [qrm_pkg::Q_W-1:0]      q;
  } lane_t;

  logic [STEPS:0]              vld;
  logic [STEPS:0]              zero;
  logic [qrm_pkg::LEN_W-1:0]   len_s [STEPS+1];
  lane_t                       ln    [STEPS+1][qrm_pkg::N_ENT];

  // init stage: quotient of one or more saturates to 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= din.vld;
    end
    zero[0]  <= din.zero;
    len_s[0] <= din.len;
    for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
      ln[0][i].full <= (din.mag[i] >= {1'b0, din.len});
      ln[0][i].neg  <= din.neg[i];
      ln[0][i].r    <= (din.mag[i] >= {1'b0, din.len}) ? '0
                       : din.mag[i][qrm_pkg::LEN_W-1:0];
      ln[0][i].q    <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [qrm_pkg::LEN_W:0]   twice [qrm_pkg::N_ENT];
    logic [qrm_pkg::LEN_W:0]   diff  [qrm_pkg::N_ENT];
    logic [qrm_pkg::N_ENT-1:0] ge;

    always_comb begin
      for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
        twice[i] = {ln[s][i].r, 1'b0};
        diff[i]  = twice[i] - {1'b0, len_s[s]};
        ge[i]    = (twice[i] >= {1'b0, len_s[s]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      zero[s+1]  <= zero[s];
      len_s[s+1] <= len_s[s];
      for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
        ln[s+1][i].full <= ln[s][i].full;
        ln[s+1][i].neg  <= ln[s][i].neg;
        ln[s+1][i].r    <= ge[i] ? diff[i][qrm_pkg::LEN_W-1:0]
                           : twice[i][qrm_pkg::LEN_W-1:0];
        ln[s+1][i].q    <= {ln[s][i].q[qrm_pkg::Q_W-2:0], ge[i]};
      end
    end
  end

  // round, restore sign
  logic [qrm_pkg::Q_W-1:0]          rq  [qrm_pkg::N_ENT];
  logic [qrm_pkg::DATA_WIDTH-1:0]   ent [qrm_pkg::N_ENT];
  logic [qrm_pkg::DATA_WIDTH-1:0]   ent_q [qrm_pkg::N_ENT];
  logic                             zero_q;

  always_comb begin
    for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
      if (ln[STEPS][i].full) begin
        rq[i] = qrm_pkg::Q_W'(1) << qrm_pkg::FRAC_BITS;
      end else begin
        rq[i] = (ln[STEPS][i].q >> 1) + qrm_pkg::Q_W'(ln[STEPS][i].q[0]);
      end
      if (zero[STEPS]) begin
        ent[i] = '0;
      end else if (ln[STEPS][i].neg) begin
        ent[i] = '0 - qrm_pkg::DATA_WIDTH'(rq[i]);
      end else begin
        ent[i] = qrm_pkg::DATA_WIDTH'(rq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[STEPS];
    end
    zero_q <= zero[STEPS];
    for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
      ent_q[i] <= ent[i];
    end
  end

  always_comb begin
    result.m_r0c0      = ent_q[0];
    result.m_r0c1      = ent_q[1];
    result.m_r0c2      = ent_q[2];
    result.m_r1c0      = ent_q[3];
    result.m_r1c1      = ent_q[4];
    result.m_r1c2      = ent_q[5];
    result.m_r2c0      = ent_q[6];
    result.m_r2c1      = ent_q[7];
    result.m_r2c2      = ent_q[8];
    result.zero_length = zero_q;
  end

endmodule

// ----- rtl/quaternion_to_rotation_matrix.sv -----
// quaternion_to_rotation_matrix: top level, products and numerators in front of
// the pipelined divider; depends on qrm_pkg and qrm_divider
//
//   channel   handshake         payload          width
//   input     start / busy      quat   (quat_t)  4 x 16
//   output    done (strobe)     result (result_t) 9 x 16 + 1
//
// one quaternion per cycle; every beat gives its result
// the divider gives one quotient bit per stage, 15 stages,
// behind a product stage, a numerator stage and an init stage, then the output register
// busy stays low; nothing can stall and results are never held back
// rst clears the valid bits only; payload registers run free

module quaternion_to_rotation_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  qrm_pkg::quat_t      quat,
  output logic                done,
  output qrm_pkg::result_t    result
);

  localparam int W  = qrm_pkg::DATA_WIDTH;
  localparam int LW = qrm_pkg::LEN_W;
  localparam int MW = qrm_pkg::MAG_W;

  assign busy = 1'b0;

  // all parts at the most negative value act as (-1,-1,-1,-1)
  logic                  all_min;
  logic signed [W-1:0]   qw, qx, qy, qz;

  always_comb begin
    all_min = (quat.quat_w == {1'b1, {(W-1){1'b0}}}) && (quat.quat_x == {1'b1, {(W-1){1'b0}}})
           && (quat.quat_y == {1'b1, {(W-1){1'b0}}}) && (quat.quat_z == {1'b1, {(W-1){1'b0}}});
    qw = all_min ? '1 : quat.quat_w;
    qx = all_min ? '1 : quat.quat_x;
    qy = all_min ? '1 : quat.quat_y;
    qz = all_min ? '1 : quat.quat_z;
  end

  // product stage
  logic                  vld1;
  logic [LW-1:0]         sw, sx, sy, sz;
  logic signed [LW-1:0]  pxy, pzw, pxz, pyw, pyz, pxw;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start & ~busy;
    end
    sw  <= $unsigned(LW'(qw) * LW'(qw));
    sx  <= $unsigned(LW'(qx) * LW'(qx));
    sy  <= $unsigned(LW'(qy) * LW'(qy));
    sz  <= $unsigned(LW'(qz) * LW'(qz));
    pxy <= LW'(qx) * LW'(qy);
    pzw <= LW'(qz) * LW'(qw);
    pxz <= LW'(qx) * LW'(qz);
    pyw <= LW'(qy) * LW'(qw);
    pyz <= LW'(qy) * LW'(qz);
    pxw <= LW'(qx) * LW'(qw);
  end

  // numerator stage
  function automatic logic [MW:0] diag_num(input logic [LW-1:0] p, input logic [LW-1:0] q);
    logic neg;
    logic [LW-1:0] m;
    neg = (q > p);
    m   = neg ? (q - p) : (p - q);
    return {neg, MW'(m)};
  endfunction

  function automatic logic [MW:0] offd_num(input logic signed [LW-1:0] a,
                                           input logic signed [LW-1:0] b,
                                           input logic sub);
    logic signed [MW-1:0] t;
    logic [MW-1:0] m;
    t = sub ? (MW'(a) - MW'(b)) : (MW'(a) + MW'(b));
    m = t[MW-1] ? ('0 - t) : t;
    return {t[MW-1], m[MW-2:0], 1'b0};
  endfunction

  logic [MW:0]           num [qrm_pkg::N_ENT];
  logic [LW-1:0]         len_c;
  qrm_pkg::div_in_t      din;

  always_comb begin
    len_c  = sw + sx + sy + sz;
    num[0] = diag_num(sx + sw, sy + sz);
    num[1] = offd_num(pxy, pzw, 1'b1);
    num[2] = offd_num(pxz, pyw, 1'b0);
    num[3] = offd_num(pxy, pzw, 1'b0);
    num[4] = diag_num(sy + sw, sx + sz);
    num[5] = offd_num(pyz, pxw, 1'b1);
    num[6] = offd_num(pxz, pyw, 1'b1);
    num[7] = offd_num(pyz, pxw, 1'b0);
    num[8] = diag_num(sz + sw, sx + sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      din.vld <= 1'b0;
    end else begin
      din.vld <= vld1;
    end
    din.len  <= len_c;
    din.zero <= (len_c == '0);
    for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
      din.neg[i] <= num[i][MW];
      din.mag[i] <= num[i][MW-1:0];
    end
  end

  qrm_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .done   (done),
    .result (result)
  );

endmodule
